// ===== hw/rtl/ip_address_text_classifier_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_UNIT_ASSERT_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_UNIT_ASSERT_SVH

// clocked property, masked while reset is active
`define IPATC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset as well
`define IPATC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ipatc_pkg.sv =====
`default_nettype none

package ipatc_pkg;

  // result codes
  typedef enum logic [1:0] {
    CLASS_IPV4 = 2'd0,
    CLASS_IPV6 = 2'd1,
    CLASS_NONE = 2'd2
  } address_class_e;

  // queue between decode and execute
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // limits of the checks
  localparam logic [8:0] V4_MAX_PART = 9'd255;
  localparam logic [8:0] V4_SAT_PART = 9'd256;
  localparam logic [2:0] SAT3        = 3'd7;
  localparam logic [3:0] SAT4        = 4'd15;
  localparam logic [2:0] V6_TOO_LONG = 3'd5;
  localparam logic [2:0] V4_DOTS     = 3'd3;
  localparam logic [3:0] V6_COLONS   = 4'd7;

  // decoded character
  typedef struct packed {
    logic       is_dec;
    logic [3:0] digit;
    logic       is_dot;
    logic       is_hex;
    logic       is_colon;
    logic       last;
  } token_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ipatc_decode.sv =====
`default_nettype none

module ipatc_decode (
  input  wire logic            s_tvalid_i,
  input  wire logic [7:0]      text_char_i,
  input  wire logic            is_last_i,
  output logic                 s_tready_o,
  input  wire logic            q_ready_i,
  output logic                 q_push_o,
  output ipatc_pkg::token_t    q_token_o
);
  import ipatc_pkg::*;

  logic dec;
  logic lower_hex;
  logic upper_hex;

  always_comb begin
    dec       = (text_char_i >= 8'h30) && (text_char_i <= 8'h39);
    lower_hex = (text_char_i >= 8'h61) && (text_char_i <= 8'h66);
    upper_hex = (text_char_i >= 8'h41) && (text_char_i <= 8'h46);

    q_token_o.is_dec   = dec;
    q_token_o.digit    = text_char_i[3:0];
    q_token_o.is_dot   = (text_char_i == 8'h2e);
    q_token_o.is_hex   = dec || lower_hex || upper_hex;
    q_token_o.is_colon = (text_char_i == 8'h3a);
    q_token_o.last     = is_last_i;
  end

  assign s_tready_o = q_ready_i;
  assign q_push_o   = s_tvalid_i && q_ready_i;

endmodule

`default_nettype wire

// ===== hw/rtl/ipatc_fifo.sv =====
`default_nettype none

module ipatc_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  ipatc_pkg::token_t      push_token_i,
  output logic                   push_ready_o,
  input  wire logic              pop_i,
  output logic                   pop_valid_o,
  output ipatc_pkg::token_t      pop_token_o
);
  import ipatc_pkg::*;

  token_t                 entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]  count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready_o = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_token_o  = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage needs no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_token_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipatc_exec.sv =====
`default_nettype none

module ipatc_exec (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  ipatc_pkg::token_t    q_token_i,
  output logic                 q_pop_o,
  input  wire logic            m_tready_i,
  output logic                 m_tvalid_o,
  output logic [7:0]           m_tdata_o
);
  import ipatc_pkg::*;

  logic       saw_dot_q, saw_dot_d;
  logic       saw_colon_q, saw_colon_d;
  logic       v4_valid_q, v4_valid_d;
  logic       v6_valid_q, v6_valid_d;
  logic [8:0] part_value_q, part_value_d;
  logic [2:0] part_digit_count_q, part_digit_count_d;
  logic       part_starts_zero_q, part_starts_zero_d;
  logic [2:0] dot_count_q, dot_count_d;
  logic [2:0] group_length_q, group_length_d;
  logic [3:0] colon_count_q, colon_count_d;
  logic       out_valid_q, out_valid_d;
  address_class_e out_class_q, out_class_d;

  logic [11:0] part_ext;
  logic [11:0] part_next;

  assign q_pop_o    = q_valid_i && (!q_token_i.last || !out_valid_q || m_tready_i);
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'b0, out_class_q};

  // times ten plus digit by two shifts and adds
  always_comb begin
    part_ext  = {3'b0, part_value_q};
    part_next = (part_ext << 3) + (part_ext << 1) + {8'b0, q_token_i.digit};
  end

  always_comb begin
    saw_dot_d          = saw_dot_q;
    saw_colon_d        = saw_colon_q;
    v4_valid_d         = v4_valid_q;
    v6_valid_d         = v6_valid_q;
    part_value_d       = part_value_q;
    part_digit_count_d = part_digit_count_q;
    part_starts_zero_d = part_starts_zero_q;
    dot_count_d        = dot_count_q;
    group_length_d     = group_length_q;
    colon_count_d      = colon_count_q;
    out_valid_d        = out_valid_q && !m_tready_i;
    out_class_d        = out_class_q;

    if (q_pop_o) begin
      // ipv4 side
      priority if (q_token_i.is_dec) begin
        if (part_digit_count_q == '0) begin
          part_starts_zero_d = (q_token_i.digit == 4'd0);
        end else if (part_starts_zero_q) begin
          v4_valid_d = 1'b0;
        end
        part_value_d = (part_next > {3'b0, V4_MAX_PART}) ? V4_SAT_PART : part_next[8:0];
        if (part_digit_count_q < SAT3) begin
          part_digit_count_d = part_digit_count_q + 1'b1;
        end
      end else if (q_token_i.is_dot) begin
        saw_dot_d = 1'b1;
        if (part_digit_count_q == '0 || part_value_q > V4_MAX_PART) begin
          v4_valid_d = 1'b0;
        end
        part_value_d       = '0;
        part_digit_count_d = '0;
        part_starts_zero_d = 1'b0;
        if (dot_count_q < SAT3) begin
          dot_count_d = dot_count_q + 1'b1;
        end
      end else begin
        v4_valid_d = 1'b0;
      end

      // ipv6 side
      priority if (q_token_i.is_hex) begin
        if (group_length_q < SAT3) begin
          group_length_d = group_length_q + 1'b1;
        end
        if (group_length_d >= V6_TOO_LONG) begin
          v6_valid_d = 1'b0;
        end
      end else if (q_token_i.is_colon) begin
        saw_colon_d = 1'b1;
        if (group_length_q == '0 || group_length_q >= V6_TOO_LONG) begin
          v6_valid_d = 1'b0;
        end
        group_length_d = '0;
        if (colon_count_q < SAT4) begin
          colon_count_d = colon_count_q + 1'b1;
        end
      end else begin
        v6_valid_d = 1'b0;
      end

      // end of string: close open part and group, decide, start over
      if (q_token_i.last) begin
        if (part_digit_count_d == '0 || part_value_d > V4_MAX_PART
            || dot_count_d != V4_DOTS) begin
          v4_valid_d = 1'b0;
        end
        if (group_length_d == '0 || group_length_d >= V6_TOO_LONG
            || colon_count_d != V6_COLONS) begin
          v6_valid_d = 1'b0;
        end
        priority if (saw_dot_d) begin
          out_class_d = v4_valid_d ? CLASS_IPV4 : CLASS_NONE;
        end else if (saw_colon_d) begin
          out_class_d = v6_valid_d ? CLASS_IPV6 : CLASS_NONE;
        end else begin
          out_class_d = CLASS_NONE;
        end
        out_valid_d        = 1'b1;
        saw_dot_d          = 1'b0;
        saw_colon_d        = 1'b0;
        v4_valid_d         = 1'b1;
        v6_valid_d         = 1'b1;
        part_value_d       = '0;
        part_digit_count_d = '0;
        part_starts_zero_d = 1'b0;
        dot_count_d        = '0;
        group_length_d     = '0;
        colon_count_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saw_dot_q          <= 1'b0;
      saw_colon_q        <= 1'b0;
      v4_valid_q         <= 1'b1;
      v6_valid_q         <= 1'b1;
      part_value_q       <= '0;
      part_digit_count_q <= '0;
      part_starts_zero_q <= 1'b0;
      dot_count_q        <= '0;
      group_length_q     <= '0;
      colon_count_q      <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      saw_dot_q          <= saw_dot_d;
      saw_colon_q        <= saw_colon_d;
      v4_valid_q         <= v4_valid_d;
      v6_valid_q         <= v6_valid_d;
      part_value_q       <= part_value_d;
      part_digit_count_q <= part_digit_count_d;
      part_starts_zero_q <= part_starts_zero_d;
      dot_count_q        <= dot_count_d;
      group_length_q     <= group_length_d;
      colon_count_q      <= colon_count_d;
      out_valid_q        <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_class_q <= out_class_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ip_address_text_classifier_unit.sv =====
// ip address text classifier
// input stream: one ascii character per transaction on s_axis, tlast marks the
//   final character of an address string
// output stream: one transaction per string on m_axis, sent after the last
//   character; tdata[1:0] is the class (0 ipv4, 1 ipv6, 2 neither)
// throughput: one character per cycle while the output is not stalled, set by
//   the execute state update; characters of the next string may follow at once
// result path: the token of the last character is first written into the decode
//   queue, then the state update pops it and loads the output register; a
//   stalled output can hold it at the head of the queue
// stalls: while m_axis_tready is low, the result holds in the output register;
//   characters that end no string keep flowing, and the two-entry queue fills
//   only once the next last character waits at its head with one more
//   character behind it, which then drops s_axis_tready
// reset: rst_ni clears the queue, the per-string state and the output valid;
//   the block takes characters from the first cycle after reset
`default_nettype none

module ip_address_text_classifier_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] text_char
  input  wire logic        s_axis_tlast_i,   // is_last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o    // [1:0] address_class, [7:2] zero
);
  import ipatc_pkg::*;

  token_t push_token;
  token_t pop_token;
  logic   push;
  logic   push_ready;
  logic   pop;
  logic   pop_valid;

  // front: decode each character into a token
  ipatc_decode u_decode (
    .s_tvalid_i  (s_axis_tvalid_i),
    .text_char_i (s_axis_tdata_i),
    .is_last_i   (s_axis_tlast_i),
    .s_tready_o  (s_axis_tready_o),
    .q_ready_i   (push_ready),
    .q_push_o    (push),
    .q_token_o   (push_token)
  );

  // short queue decouples decode from the state update
  ipatc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_token_i (push_token),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_token_o  (pop_token)
  );

  // back: ipv4 and ipv6 checks side by side, result register
  ipatc_exec u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (pop_valid),
    .q_token_i  (pop_token),
    .q_pop_o    (pop),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ipatc_checker.sv =====
`default_nettype none

`include "ip_address_text_classifier_unit_assert.svh"

module ipatc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid_i,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_i
);

  `IPATC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i), "stalled result changed")
  `IPATC_ASSERT(a_class_legal, clk_i, rst_ni, m_axis_tvalid_i |-> (m_axis_tdata_i[1:0] != 2'd3) && (m_axis_tdata_i[7:2] == 6'd0), "illegal class code")
  `IPATC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid_i, "result valid in reset")

endmodule

bind ip_address_text_classifier_unit ipatc_checker u_ipatc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire
